>>> rtl/core/deqs_pkg.sv
// Package for the double-ended queue with value search.
// Holds sizes, operation and status codes, and the request, result and cell control types.
// Depends on nothing; every module of the block imports it.
`default_nettype none
package deqs_pkg;

  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 32;
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [2:0] OP_POP_FRONT  = 3'd2;
  localparam logic [2:0] OP_POP_BACK   = 3'd3;
  localparam logic [2:0] OP_CONTAINS   = 3'd4;
  localparam logic [2:0] OP_REMOVE     = 3'd5;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_EMPTY     = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  typedef struct packed {
    logic [2:0]  operation;
    logic [31:0] value;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        found;
    logic [31:0] front_value;
    logic [31:0] back_value;
    logic [4:0]  item_count;
    logic        is_empty;
  } out_t;

  // Control broadcast from the top level to every cell.
  typedef struct packed {
    logic                  go;
    logic [2:0]            operation;
    logic [DATA_WIDTH-1:0] value;
    logic                  full;
    logic                  empty;
  } cell_ctl_t;

endpackage
`default_nettype wire

>>> rtl/core/deqs_cell.sv
// One storage cell of the queue: holds an entry, compares it to the search value,
// and loads from its left or right neighbor to shift the row. Depends on deqs_pkg.
`default_nettype none
module deqs_cell (
  input  wire logic                           clk,
  input  wire deqs_pkg::cell_ctl_t            ctl,
  input  wire logic                           occupied,
  input  wire logic                           is_tail,
  input  wire logic [deqs_pkg::DATA_WIDTH-1:0] left_data,
  input  wire logic [deqs_pkg::DATA_WIDTH-1:0] right_data,
  input  wire logic                           seen_in,
  output logic [deqs_pkg::DATA_WIDTH-1:0]      data,
  output logic                                seen_out
);
  import deqs_pkg::*;

  logic [DATA_WIDTH-1:0] data_r;
  logic [DATA_WIDTH-1:0] data_nxt;
  logic                  match;

  assign match    = occupied && (data_r == ctl.value);
  // Once a match has been seen at or before this cell, a removal shifts it.
  assign seen_out = seen_in | match;
  assign data     = data_r;

  always_comb begin
    data_nxt = data_r;
    if (ctl.go) begin
      case (ctl.operation)
        OP_PUSH_FRONT: if (!ctl.full) data_nxt = left_data;
        OP_PUSH_BACK:  if (!ctl.full && is_tail) data_nxt = ctl.value;
        OP_POP_FRONT:  if (!ctl.empty) data_nxt = right_data;
        OP_REMOVE:     if (seen_out) data_nxt = right_data;
        default:       data_nxt = data_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

endmodule
`default_nettype wire

>>> rtl/core/deque_with_value_search.sv
// Double-ended queue of DEPTH entries with value search, built as a row of cells.
// The result of an accepted request is registered at the end of the busy cycle and is
// on the ports, with out_valid high, for one cycle. Requests are taken only while busy
// is low; busy is high for the cycle after acceptance, while the row settles and the
// front and back entries are read out. Search is combinational through the cell row;
// removals and shifts are written into the cells when the request is taken.
// Reset (synchronous, active low) empties the queue and clears busy and out_valid.
`default_nettype none
module deque_with_value_search (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start,
  output logic                busy,
  input  wire deqs_pkg::in_t  in_req,
  output logic                out_valid,
  output deqs_pkg::out_t      out_res
);
  import deqs_pkg::*;

  logic [CNT_W-1:0]      count_r, count_nxt;
  logic                  phase_r;
  logic [1:0]            status_r, status_nxt;
  logic                  found_r, found_nxt;
  logic                  out_valid_r;
  out_t                  out_res_r;

  cell_ctl_t             ctl;
  logic                  accept;
  logic                  full, empty, any_match;
  logic [DATA_WIDTH-1:0] cell_data [DEPTH];
  logic [DEPTH:0]        seen;
  logic [IDX_W-1:0]      back_idx;

  assign accept = start && !phase_r;
  assign busy   = phase_r;
  assign full   = (count_r == CNT_W'(DEPTH));
  assign empty  = (count_r == '0);

  assign ctl.go        = accept;
  assign ctl.operation = in_req.operation;
  assign ctl.value     = in_req.value[DATA_WIDTH-1:0];
  assign ctl.full      = full;
  assign ctl.empty     = empty;

  assign seen[0] = 1'b0;

  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      logic [DATA_WIDTH-1:0] left_d, right_d;
      if (gi == 0) begin : g_first
        assign left_d = ctl.value;
      end else begin : g_mid
        assign left_d = cell_data[gi-1];
      end
      if (gi == DEPTH - 1) begin : g_last
        assign right_d = cell_data[gi];
      end else begin : g_inner
        assign right_d = cell_data[gi+1];
      end
      deqs_cell u_cell (
        .clk        (clk),
        .ctl        (ctl),
        .occupied   (CNT_W'(gi) < count_r),
        .is_tail    (CNT_W'(gi) == count_r),
        .left_data  (left_d),
        .right_data (right_d),
        .seen_in    (seen[gi]),
        .data       (cell_data[gi]),
        .seen_out   (seen[gi+1])
      );
    end
  endgenerate

  assign any_match = seen[DEPTH];

  always_comb begin
    count_nxt  = count_r;
    status_nxt = ST_OK;
    found_nxt  = 1'b0;
    case (in_req.operation)
      OP_PUSH_FRONT, OP_PUSH_BACK: begin
        if (full) status_nxt = ST_FULL;
        else count_nxt = count_r + CNT_W'(1);
      end
      OP_POP_FRONT, OP_POP_BACK: begin
        if (empty) status_nxt = ST_EMPTY;
        else count_nxt = count_r - CNT_W'(1);
      end
      OP_CONTAINS: begin
        if (any_match) found_nxt = 1'b1;
        else status_nxt = ST_NOT_FOUND;
      end
      OP_REMOVE: begin
        if (any_match) begin
          found_nxt = 1'b1;
          count_nxt = count_r - CNT_W'(1);
        end else begin
          status_nxt = ST_NOT_FOUND;
        end
      end
      default: begin
        count_nxt = count_r;
      end
    endcase
  end

  assign back_idx = IDX_W'(count_r - CNT_W'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      phase_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      if (accept) begin
        count_r  <= count_nxt;
        phase_r  <= 1'b1;
        status_r <= status_nxt;
        found_r  <= found_nxt;
      end else if (phase_r) begin
        phase_r               <= 1'b0;
        out_valid_r           <= 1'b1;
        out_res_r.status      <= status_r;
        out_res_r.found       <= found_r;
        out_res_r.item_count  <= 5'(count_r);
        out_res_r.is_empty    <= empty;
        out_res_r.front_value <= empty ? '0 : 32'(cell_data[0]);
        out_res_r.back_value  <= empty ? '0 : 32'(cell_data[back_idx]);
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule
`default_nettype wire

>>> rtl/core/deqs_checker.sv
// Port-level assertions for the double-ended queue, bound to the top level.
// Depends on deqs_pkg and the ports of deque_with_value_search.
`default_nettype none
module deqs_assert (
  input wire logic           clk,
  input wire logic           rst_n,
  input wire logic           start,
  input wire logic           busy,
  input wire deqs_pkg::in_t  in_req,
  input wire logic           out_valid,
  input wire deqs_pkg::out_t out_res
);
  import deqs_pkg::*;

  // An accepted request makes the block busy in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("busy not raised after request");

  // A busy cycle is always followed by a result, with busy low again.
  a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> (out_valid && !busy)) else $error("no result after busy cycle");

  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_res.is_empty == (out_res.item_count == 5'd0)))
    else $error("is_empty disagrees with item_count");

  a_empty_values: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_res.is_empty) |->
      (out_res.front_value == 32'd0 && out_res.back_value == 32'd0))
    else $error("nonzero front or back on empty queue");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_res.item_count <= 5'(DEPTH)))
    else $error("item_count beyond depth");

endmodule

bind deque_with_value_search deqs_assert u_deqs_assert (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_req    (in_req),
  .out_valid (out_valid),
  .out_res   (out_res)
);
`default_nettype wire

>>> sim/deqs_checker.sv
// Checker for the double-ended queue with value search: it mirrors the queue contents
// and compares every result with the predicted one. Depends on deqs_pkg for the
// request and result types and for the operation and status codes.
module deqs_checker
  import deqs_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  logic busy,
  input  in_t  in_req,
  input  logic out_valid,
  input  out_t out_res,
  output int   fail_count,
  output int   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [DATA_WIDTH-1:0] dq_cells [DEPTH];
  int                    dq_count;
  out_t                  expected_views [$];
  int                    mismatches;

  // Applies one request to the mirrored queue and returns the view of the queue
  // that the block should report afterwards.
  function automatic out_t dq_apply(in_t req);
    logic [DATA_WIDTH-1:0] v;
    out_t                  r;
    int                    hit;
    v = req.value;
    r = '0;
    r.status = ST_OK;
    hit = -1;
    for (int i = 0; i < dq_count; i++) begin
      if (hit < 0 && dq_cells[i] == v) hit = i;
    end
    case (req.operation)
      OP_PUSH_FRONT: begin
        if (dq_count >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          for (int i = dq_count; i > 0; i--) dq_cells[i] = dq_cells[i-1];
          dq_cells[0] = v;
          dq_count++;
        end
      end
      OP_PUSH_BACK: begin
        if (dq_count >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          dq_cells[dq_count] = v;
          dq_count++;
        end
      end
      OP_POP_FRONT: begin
        if (dq_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          for (int i = 0; i + 1 < dq_count; i++) dq_cells[i] = dq_cells[i+1];
          dq_count--;
        end
      end
      OP_POP_BACK: begin
        if (dq_count == 0) r.status = ST_EMPTY;
        else dq_count--;
      end
      OP_CONTAINS: begin
        if (hit >= 0) r.found = 1'b1;
        else r.status = ST_NOT_FOUND;
      end
      OP_REMOVE: begin
        if (hit >= 0) begin
          r.found = 1'b1;
          for (int i = hit; i + 1 < dq_count; i++) dq_cells[i] = dq_cells[i+1];
          dq_count--;
        end else begin
          r.status = ST_NOT_FOUND;
        end
      end
      default: ;
    endcase
    if (dq_count > 0) begin
      r.front_value = dq_cells[0];
      r.back_value  = dq_cells[dq_count-1];
    end
    r.item_count = 5'(dq_count);
    r.is_empty   = (dq_count == 0);
    return r;
  endfunction

  always @(posedge clk) begin
    out_t want;
    if (!rst_n) begin
      dq_count = 0;
      mismatches = 0;
      expected_views.delete();
    end else begin
      // The older result is retired before a request taken at the same edge is added.
      if (out_valid) begin
        if (expected_views.size() == 0) begin
          $display("%0t: result with none expected, actual %h", $time, out_res);
          mismatches++;
        end else begin
          want = expected_views.pop_front();
          if (out_res.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status,
                     out_res.status);
            mismatches++;
          end
          if (out_res.found !== want.found) begin
            $display("%0t: found expected %0d actual %0d", $time, want.found,
                     out_res.found);
            mismatches++;
          end
          if (out_res.front_value !== want.front_value) begin
            $display("%0t: front_value expected %h actual %h", $time, want.front_value,
                     out_res.front_value);
            mismatches++;
          end
          if (out_res.back_value !== want.back_value) begin
            $display("%0t: back_value expected %h actual %h", $time, want.back_value,
                     out_res.back_value);
            mismatches++;
          end
          if (out_res.item_count !== want.item_count) begin
            $display("%0t: item_count expected %0d actual %0d", $time, want.item_count,
                     out_res.item_count);
            mismatches++;
          end
          if (out_res.is_empty !== want.is_empty) begin
            $display("%0t: is_empty expected %0d actual %0d", $time, want.is_empty,
                     out_res.is_empty);
            mismatches++;
          end
        end
      end
      if (start && !busy) expected_views.push_back(dq_apply(in_req));
    end
    fail_count <= mismatches;
    pending    <= expected_views.size();
  end

endmodule

>>> sim/tb_deque_with_value_search.sv
// Top of the testbench for deque_with_value_search: clock, reset, request stimulus
// and the verdict. Depends on deqs_pkg, the block itself and deqs_checker.
module tb_deque_with_value_search;
  timeunit 1ns;
  timeprecision 1ps;
  import deqs_pkg::*;

  localparam logic [2:0] OP_SPARE_LO = 3'd6;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;
  localparam int         NUM_REQS    = 1550;

  localparam int KIND_FILL  = 0;
  localparam int KIND_DRAIN = 1;
  localparam int KIND_MIXED = 2;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        start;
  logic        busy;
  in_t         in_req;
  logic        out_valid;
  out_t        out_res;
  int          fail_count;
  int          pending;
  int          sent;
  logic [31:0] val_pool [6];

  always #5ns clk = ~clk;

  deque_with_value_search uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

  deqs_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_req     (in_req),
    .out_valid  (out_valid),
    .out_res    (out_res),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // Called at a rising edge; returns at the edge where the request is taken, with
  // start still high so that a following request can go out back to back.
  task automatic send_req(logic [2:0] op, logic [31:0] val);
    in_t req;
    req.operation = op;
    req.value     = val;
    start  <= 1'b1;
    in_req <= req;
    @(posedge clk);
    while (busy) @(posedge clk);
    sent++;
  endtask

  task automatic idle_gap(bit allow);
    int n;
    int r;
    r = $urandom_range(0, 99);
    if (!allow || r < 55) n = 0;
    else if (r < 85) n = $urandom_range(1, 2);
    else if (r < 97) n = $urandom_range(3, 6);
    else n = $urandom_range(10, 40);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic logic [2:0] pick_op(int kind);
    int r;
    int push_w;
    int pop_w;
    int find_w;
    case (kind)
      KIND_FILL:  begin push_w = 65; pop_w = 10; find_w = 12; end
      KIND_DRAIN: begin push_w = 15; pop_w = 55; find_w = 12; end
      default:    begin push_w = 30; pop_w = 30; find_w = 20; end
    endcase
    if ($urandom_range(0, 99) < 3) return $urandom_range(0, 1) ? OP_SPARE_HI : OP_SPARE_LO;
    r = $urandom_range(0, 99);
    if (r < push_w) return $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
    if (r < push_w + pop_w) return $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK;
    if (r < push_w + pop_w + find_w) return OP_CONTAINS;
    return OP_REMOVE;
  endfunction

  // Values mostly come from a small pool so that searches hit and duplicates occur.
  function automatic logic [31:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return val_pool[$urandom_range(0, 5)];
    if (r < 60) return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0000_0000;
    return $urandom();
  endfunction

  initial begin
    int  kind;
    int  len;
    bit  gaps;
    bit  first;
    rst_n  <= 1'b0;
    start  <= 1'b0;
    in_req <= '0;
    sent = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Empty queue cases, spare codes, both ends, duplicates and removal from
    // the front, the middle and the back.
    send_req(OP_POP_FRONT, 32'h0000_0000);
    send_req(OP_POP_BACK, 32'hFFFF_FFFF);
    send_req(OP_CONTAINS, 32'h0000_0000);
    send_req(OP_REMOVE, 32'h0000_0000);
    send_req(OP_SPARE_LO, 32'h1234_5678);
    send_req(OP_SPARE_HI, 32'hFFFF_FFFF);
    send_req(OP_PUSH_BACK, 32'h0000_0000);
    send_req(OP_CONTAINS, 32'h0000_0000);
    send_req(OP_PUSH_FRONT, 32'hFFFF_FFFF);
    send_req(OP_PUSH_BACK, 32'h5555_5555);
    send_req(OP_PUSH_FRONT, 32'hAAAA_AAAA);
    send_req(OP_PUSH_BACK, 32'h0000_0000);
    send_req(OP_CONTAINS, 32'h1234_5678);
    send_req(OP_REMOVE, 32'h0000_0000);
    send_req(OP_REMOVE, 32'hAAAA_AAAA);
    send_req(OP_REMOVE, 32'h0000_0000);
    send_req(OP_POP_FRONT, 32'h8000_0000);
    send_req(OP_POP_BACK, 32'h0000_0001);
    send_req(OP_POP_BACK, 32'h0000_0000);
    wait_drained();

    first = 1'b1;
    while (sent < NUM_REQS) begin
      kind  = first ? KIND_FILL : $urandom_range(KIND_FILL, KIND_MIXED);
      first = 1'b0;
      len   = $urandom_range(10, 60);
      gaps  = ($urandom_range(0, 3) != 0);
      foreach (val_pool[i]) begin
        val_pool[i] = ($urandom_range(0, 3) == 0) ? 32'($urandom_range(0, 7)) : $urandom();
      end
      for (int n = 0; n < len && sent < NUM_REQS; n++) begin
        send_req(pick_op(kind), pick_value());
        idle_gap(gaps);
      end
      if ($urandom_range(0, 3) == 0) wait_drained();
    end

    wait_drained();
    repeat (4) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("deque_with_value_search test passed");
    end else begin
      $display("deque_with_value_search test failed");
    end
    $finish;
  end

  initial begin
    #3ms;
    $display("deque_with_value_search test failed");
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/deqs_pkg.sv
rtl/core/deqs_cell.sv
rtl/core/deque_with_value_search.sv
rtl/core/deqs_checker.sv
sim/deqs_checker.sv
sim/tb_deque_with_value_search.sv
